@@ sv/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property a implies b in the same cycle
`define ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// property a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

@@ sv/ddo_pkg.sv @@
// types and constants of the odometry block
package ddo_pkg;
   localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
   localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032875;
   localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;
   localparam logic [0:0] CSR_DIST = 1'b0;
   localparam logic [0:0] CSR_INVB = 1'b1;
   // product selects
   localparam logic [1:0] MUL_X = 2'd0;
   localparam logic [1:0] MUL_Y = 2'd1;
   localparam logic [1:0] MUL_H = 2'd2;

   function automatic logic [27:0] atan_q28(input logic [4:0] k);
      logic [27:0] t;
      case (k)
         5'd0: t = 28'd210828714;
         5'd1: t = 28'd124459457;
         5'd2: t = 28'd65760959;
         5'd3: t = 28'd33381290;
         5'd4: t = 28'd16755422;
         5'd5: t = 28'd8385879;
         5'd6: t = 28'd4193963;
         5'd7: t = 28'd2097109;
         5'd8: t = 28'd1048571;
         5'd9: t = 28'd524287;
         5'd28: t = 28'd1;
         5'd29, 5'd30, 5'd31: t = 28'd0;
         default: t = 28'd1 << (5'd28 - k);
      endcase
      return t;
   endfunction

   typedef struct packed {
      logic start;
      logic mul_go;
      logic [1:0] mul_sel;
      logic cordic_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic cordic_done;
      logic zero_move;
   } sts_type;
endpackage

@@ sv/ddo_if.sv @@
// valid/ready channel interfaces
interface ddo_req_if;
   logic valid;
   logic ready;
   logic signed [19:0] left_count;
   logic signed [19:0] right_count;
   logic reset_position;
   modport source (output valid, left_count, right_count, reset_position, input ready);
   modport sink (input valid, left_count, right_count, reset_position, output ready);
endinterface

interface ddo_rsp_if;
   logic valid;
   logic ready;
   logic signed [47:0] x_out;
   logic signed [47:0] y_out;
   logic signed [31:0] heading_out;
   modport source (output valid, x_out, y_out, heading_out, input ready);
   modport sink (input valid, x_out, y_out, heading_out, output ready);
endinterface

interface ddo_csr_if;
   logic valid;
   logic ready;
   logic [0:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ddo_mul.sv @@
// sequential signed multiplier, 16 bits of b per cycle
module ddo_mul (
   input  logic clock,
   input  logic reset,
   input  logic go,
   input  logic signed [53:0] a,
   input  logic signed [33:0] b,
   output logic done,
   output logic signed [87:0] p
);
   logic [53:0] ua_ff, ua_in;
   logic [33:0] ub_ff, ub_in;
   logic [87:0] acc_ff, acc_in;
   logic neg_ff, neg_in;
   logic [1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [15:0] chunk;

   always_comb begin
      chunk = ub_ff[15:0];
      ua_in = ua_ff; ub_in = ub_ff; acc_in = acc_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (go) begin
         ua_in = a[53] ? 54'(-a) : 54'(a);
         ub_in = b[33] ? 34'(-b) : 34'(b);
         neg_in = a[53] ^ b[33];
         acc_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + ((88'(ua_ff) * 88'(chunk)) << (6'(cnt_ff) * 6'd16));
         ub_in = ub_ff >> 16;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      ua_ff <= ua_in; ub_ff <= ub_in; acc_ff <= acc_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign p = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
endmodule

@@ sv/ddo_datapath.sv @@
// odometry datapath: scaling, cordic, products, pose registers
module ddo_datapath #(
   parameter int CORDIC_ITERATIONS  = 24,
   parameter int POSITION_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  ddo_pkg::cmd_type cmd,
   output ddo_pkg::sts_type sts,
   input  logic signed [19:0] left_count,
   input  logic signed [19:0] right_count,
   input  logic reset_position,
   input  logic csr_we,
   input  logic [0:0] csr_index,
   input  logic [31:0] csr_data,
   output logic signed [47:0] x_pos,
   output logic signed [47:0] y_pos,
   output logic signed [31:0] head
);
   localparam int PSH = 55 - POSITION_FRAC_BITS;
   localparam logic [4:0] LAST = 5'(CORDIC_ITERATIONS - 1);

   logic [31:0] dpc_ff, ib_ff;
   logic signed [19:0] l_ff, r_ff;
   logic signed [47:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] h_ff, h_in;
   logic signed [53:0] dl_ff, dr_ff;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic flip_ff, flip_in;
   logic [4:0] k_ff, k_in;
   logic cdone_ff, cdone_in;
   logic signed [53:0] ma;
   logic signed [33:0] mb;
   logic mdone;
   logic signed [87:0] mp;
   logic signed [87:0] px_ff, py_ff;
   logic signed [33:0] ang;

   // step magnitude shift and cap, sign kept
   function automatic logic signed [49:0] cap_shift(input logic signed [87:0] p,
                                                     input int sh, input int capb);
      logic [87:0] m, q;
      logic signed [49:0] r;
      m = p[87] ? 88'(-p) : 88'(p);
      q = m >> sh;
      if (q > (88'd1 << capb)) q = 88'd1 << capb;
      r = p[87] ? -$signed(50'(q)) : $signed(50'(q));
      return r;
   endfunction

   always_comb begin
      ang = 34'(h_ff);
      flip_in = flip_ff;
      if (ang > ddo_pkg::PI_Q28) ang = ang - ddo_pkg::TWO_PI_Q28;
      else if (ang < -ddo_pkg::PI_Q28) ang = ang + ddo_pkg::TWO_PI_Q28;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; k_in = k_ff; cdone_in = 1'b0;
      if (cmd.start) begin
         flip_in = 1'b0;
         if (ang > ddo_pkg::HALF_PI_Q28) begin
            ang = ang - ddo_pkg::PI_Q28; flip_in = 1'b1;
         end else if (ang < -ddo_pkg::HALF_PI_Q28) begin
            ang = ang + ddo_pkg::PI_Q28; flip_in = 1'b1;
         end
         cx_in = ddo_pkg::GAIN_Q30; cy_in = '0; cz_in = ang; k_in = '0;
      end else if (cmd.cordic_step) begin
         if (!cz_ff[33]) begin
            cx_in = cx_ff - (cy_ff >>> k_ff);
            cy_in = cy_ff + (cx_ff >>> k_ff);
            cz_in = cz_ff - $signed({6'd0, ddo_pkg::atan_q28(k_ff)});
         end else begin
            cx_in = cx_ff + (cy_ff >>> k_ff);
            cy_in = cy_ff - (cx_ff >>> k_ff);
            cz_in = cz_ff + $signed({6'd0, ddo_pkg::atan_q28(k_ff)});
         end
         k_in = k_ff + 5'd1;
         cdone_in = (k_ff == LAST);
      end
   end

   // product operands: x, y, heading
   always_comb begin
      case (cmd.mul_sel)
         ddo_pkg::MUL_X: begin ma = dl_ff + dr_ff; mb = flip_ff ? -cx_ff : cx_ff; end
         ddo_pkg::MUL_Y: begin ma = dl_ff + dr_ff; mb = flip_ff ? -cy_ff : cy_ff; end
         default: begin ma = dr_ff - dl_ff; mb = $signed({2'b00, ib_ff}); end
      endcase
   end

   ddo_mul u_mul (.clock(clock), .reset(reset), .go(cmd.mul_go), .a(ma), .b(mb),
                  .done(mdone), .p(mp));

   always_comb begin
      logic signed [49:0] sx, sy, dh;
      logic signed [35:0] hh;
      x_in = x_ff; y_in = y_ff; h_in = h_ff;
      sx = cap_shift(px_ff, PSH, 48);
      sy = cap_shift(py_ff, PSH, 48);
      // heading product is taken as it completes, on the commit cycle
      dh = cap_shift(mp, 20, 34);
      hh = '0;
      if (cmd.start && reset_position) begin
         x_in = '0; y_in = '0;
      end
      if (cmd.commit) begin
         sx = 50'(x_ff) + sx;
         sy = 50'(y_ff) + sy;
         x_in = (sx > 50'(ddo_pkg::POS_MAX)) ? ddo_pkg::POS_MAX :
                (sx < 50'(ddo_pkg::POS_MIN)) ? ddo_pkg::POS_MIN : 48'(sx);
         y_in = (sy > 50'(ddo_pkg::POS_MAX)) ? ddo_pkg::POS_MAX :
                (sy < 50'(ddo_pkg::POS_MIN)) ? ddo_pkg::POS_MIN : 48'(sy);
         hh = 36'(h_ff) + 36'(dh);
         if (hh > 36'(2 * ddo_pkg::TWO_PI_Q28)) hh = 36'(2 * ddo_pkg::TWO_PI_Q28);
         else if (hh < -36'(2 * ddo_pkg::TWO_PI_Q28)) hh = -36'(2 * ddo_pkg::TWO_PI_Q28);
         if (hh > 36'(ddo_pkg::TWO_PI_Q28)) hh = hh - 36'(ddo_pkg::TWO_PI_Q28);
         else if (hh < -36'(ddo_pkg::TWO_PI_Q28)) hh = hh + 36'(ddo_pkg::TWO_PI_Q28);
         h_in = 32'(hh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= 32'd234237; ib_ff <= 32'd559241;
         x_ff <= '0; y_ff <= '0; h_ff <= '0; cdone_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == ddo_pkg::CSR_DIST) dpc_ff <= csr_data;
         if (csr_we && csr_index == ddo_pkg::CSR_INVB) ib_ff <= csr_data;
         x_ff <= x_in; y_ff <= y_in; h_ff <= h_in; cdone_ff <= cdone_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; k_ff <= k_in; flip_ff <= flip_in;
      if (cmd.start) begin
         l_ff <= left_count; r_ff <= right_count;
      end
      // scaled distances, one narrow product each
      dl_ff <= 54'(l_ff) * $signed({22'd0, dpc_ff});
      dr_ff <= -(54'(r_ff) * $signed({22'd0, dpc_ff}));
      if (mdone && cmd.mul_sel == ddo_pkg::MUL_X) px_ff <= mp;
      if (mdone && cmd.mul_sel == ddo_pkg::MUL_Y) py_ff <= mp;
   end

   assign sts.mul_done = mdone;
   assign sts.cordic_done = cdone_ff;
   assign sts.zero_move = (l_ff == '0) && (r_ff == '0);
   assign x_pos = x_ff;
   assign y_pos = y_ff;
   assign head = h_ff;
endmodule

@@ sv/ddo_ctrl.sv @@
// odometry sequencer
module ddo_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic rsp_fire,
   input  ddo_pkg::sts_type sts,
   output ddo_pkg::cmd_type cmd,
   output logic idle,
   output logic rsp_valid
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_SCALE = 7'b0000010, S_CORDIC = 7'b0000100,
      S_MULX = 7'b0001000, S_MULY = 7'b0010000, S_MULH = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;
   state_type st_ff, st_in;
   logic [1:0] sel_ff, sel_in;
   logic go_ff, go_in;

   always_comb begin
      st_in = st_ff; sel_in = sel_ff; go_in = 1'b0;
      cmd = '0;
      cmd.mul_sel = sel_ff;
      cmd.mul_go = go_ff;
      case (st_ff)
         S_IDLE: if (req_fire) begin cmd.start = 1'b1; st_in = S_SCALE; end
         S_SCALE: if (sts.zero_move) st_in = S_OUT;
                  else begin st_in = S_CORDIC; cmd.cordic_step = 1'b1; end
         S_CORDIC: begin
            if (sts.cordic_done) begin
               st_in = S_MULX; sel_in = ddo_pkg::MUL_X; go_in = 1'b1;
            end
            else cmd.cordic_step = 1'b1;
         end
         S_MULX: if (sts.mul_done) begin
            st_in = S_MULY; sel_in = ddo_pkg::MUL_Y; go_in = 1'b1;
         end
         S_MULY: if (sts.mul_done) begin
            st_in = S_MULH; sel_in = ddo_pkg::MUL_H; go_in = 1'b1;
         end
         S_MULH: if (sts.mul_done) begin st_in = S_OUT; cmd.commit = 1'b1; end
         S_OUT: if (rsp_fire) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; sel_ff <= ddo_pkg::MUL_X; go_ff <= 1'b0;
      end else begin
         st_ff <= st_in; sel_ff <= sel_in; go_ff <= go_in;
      end
   end

   assign idle = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);
endmodule

@@ sv/differential_drive_odometry.sv @@
// top level of the differential drive odometry block
// when both counts are zero the cordic and the products are skipped
// one word at a time: a new word is taken only after the result has been taken
// each word runs through the shared cordic stage and three products on one sequential multiplier
// synchronous active-high reset zeroes pose and restores the register defaults
`include "assert_macros.svh"
module differential_drive_odometry #(
   parameter int CORDIC_ITERATIONS  = 24,
   parameter int POSITION_FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   ddo_req_if.sink   req,
   ddo_rsp_if.source rsp,
   ddo_csr_if.sink   csr
);
   ddo_pkg::cmd_type cmd;
   ddo_pkg::sts_type sts;
   logic idle, req_fire, rsp_fire, csr_fire;

   // a word enters only when idle; the result is held until taken
   assign req.ready = idle;
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   // register writes always accepted
   assign csr.ready = 1'b1;
   assign csr_fire = csr.valid && csr.ready;

   ddo_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_fire(rsp_fire),
      .sts(sts), .cmd(cmd), .idle(idle), .rsp_valid(rsp.valid)
   );

   ddo_datapath #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS), .POSITION_FRAC_BITS(POSITION_FRAC_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .left_count(req.left_count), .right_count(req.right_count),
      .reset_position(req.reset_position),
      .csr_we(csr_fire), .csr_index(csr.index), .csr_data(csr.data),
      .x_pos(rsp.x_out), .y_pos(rsp.y_out), .head(rsp.heading_out)
   );

   // heading stays inside one turn
   `ASSERT_IMP(a_head_range, clock, reset, rsp.valid, (rsp.heading_out <= 32'sd1686629713) && (rsp.heading_out >= -32'sd1686629713))
   // no word taken while a result is pending
   `ASSERT_IMP(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   // a held result keeps x_out stable
   `ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready, $stable(rsp.x_out))
endmodule
